>>> rtl/sorted_reminder_insert_table_assert.svh
// Assertion macros for the sorted reminder table.
// Each expects clk and rst_n to be visible where it is used.
`ifndef SORTED_REMINDER_INSERT_TABLE_ASSERT_SVH
`define SORTED_REMINDER_INSERT_TABLE_ASSERT_SVH

// Same-cycle implication.
`define SRIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted reminder table: same-cycle check failed");

// Next-cycle implication.
`define SRIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted reminder table: next-cycle check failed");

`endif

>>> rtl/srit_pkg.sv
`default_nettype none

package srit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TAG_WIDTH   = 16;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int DAY_MAX    = 31;
  localparam int HOUR_MAX   = 23;
  localparam int MINUTE_MAX = 59;

  localparam logic [15:0] TAG_MASK = 16'((33'h1 << TAG_WIDTH) - 33'h1);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [15:0]        key_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_DAY  = 3'd2,
    ST_BAD_TIME = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LIST   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic full;
    logic bad_day;
    logic bad_time;
  } check_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_LST_RD,
    S_LST_OUT,
    S_EMIT
  } state_t;

  function automatic key_t key_of(entry_t e);
    return {e.day, e.hour, e.minute};
  endfunction

endpackage

`default_nettype wire

>>> rtl/srit_validate.sv
`default_nettype none

module srit_validate (
  input  wire logic [6:0]       day_in,
  input  wire logic [6:0]       hour_in,
  input  wire logic [6:0]       minute_in,
  input  wire logic [15:0]      tag_in,
  input  wire srit_pkg::count_t count,
  output srit_pkg::check_t      chk,
  output srit_pkg::entry_t      entry
);

  always_comb begin
    chk.full     = (count >= srit_pkg::count_t'(srit_pkg::TABLE_DEPTH));
    chk.bad_day  = (day_in == 7'd0) || (day_in > 7'(srit_pkg::DAY_MAX));
    chk.bad_time = (hour_in > 7'(srit_pkg::HOUR_MAX)) ||
                   (minute_in > 7'(srit_pkg::MINUTE_MAX));
  end

  // Fields are only stored once the checks pass, so the narrowing is safe.
  always_comb begin
    entry.day    = day_in[4:0];
    entry.hour   = hour_in[4:0];
    entry.minute = minute_in[5:0];
    entry.tag    = tag_in & srit_pkg::TAG_MASK;
  end

endmodule

`default_nettype wire

>>> rtl/sorted_reminder_insert_table.sv
`default_nettype none

// Sorted reminder table: up to 64 entries kept in order of day, hour and
// minute in a single-port-write, registered-read memory. The block takes one
// item at a time; in_stall stays high until the item's last result has been
// loaded into the output register. An insert that is rejected or goes into an
// empty table, and a list of an empty table, go from decode straight to the
// emit state. A valid insert scans from the bottom of the table upward, a read
// and then a compare and write through the one key comparator for each entry
// that moves down. One more read and compare finds the slot for the new entry;
// when every stored entry moves, the new entry is written to the top in its
// own put state. A list does one memory read per result. A stall of the
// output holds the emit and list-output states. There is no clearing pass
// after reset.
module sorted_reminder_insert_table (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [6:0]  in_day_in,
  input  wire logic [6:0]  in_hour_in,
  input  wire logic [6:0]  in_minute_in,
  input  wire logic [15:0] in_tag_in,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [4:0]       out_day_out,
  output logic [4:0]       out_hour_out,
  output logic [5:0]       out_minute_out,
  output logic [15:0]      out_tag_out,
  output logic             out_last
);

  srit_pkg::state_t  state_r, state_nxt;
  srit_pkg::cmd_t    cmd_r;
  logic [6:0]        day_r, hour_r, minute_r;
  logic [15:0]       tag_r;
  srit_pkg::count_t  count_r, count_nxt;
  srit_pkg::addr_t   ptr_r, ptr_nxt;
  srit_pkg::status_t status_r, status_nxt;

  srit_pkg::entry_t  mem [srit_pkg::TABLE_DEPTH];
  srit_pkg::entry_t  rd_data_r;
  logic              mem_we, mem_re;
  srit_pkg::addr_t   mem_waddr, mem_raddr;
  srit_pkg::entry_t  mem_wdata;

  logic              out_valid_r;
  srit_pkg::status_t out_status_r, out_status_nxt;
  srit_pkg::entry_t  out_entry_r, out_entry_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load, out_free;

  srit_pkg::check_t  chk;
  srit_pkg::entry_t  new_entry;
  logic              shift_down;
  logic              list_last;

  srit_validate u_validate (
    .day_in    (day_r),
    .hour_in   (hour_r),
    .minute_in (minute_r),
    .tag_in    (tag_r),
    .count     (count_r),
    .chk       (chk),
    .entry     (new_entry)
  );

  assign in_stall   = (state_r != srit_pkg::S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  // Stored entries with a key not below the new one move down.
  assign shift_down = (srit_pkg::key_of(rd_data_r) >= srit_pkg::key_of(new_entry));
  assign list_last  = (srit_pkg::count_t'(ptr_r) + srit_pkg::count_t'(1)) == count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srit_pkg::S_IDLE: begin
        if (in_valid) state_nxt = srit_pkg::S_DECODE;
      end
      srit_pkg::S_DECODE: begin
        if (cmd_r == srit_pkg::CMD_INSERT) begin
          if (chk.full || chk.bad_day || chk.bad_time || count_r == '0) begin
            state_nxt = srit_pkg::S_EMIT;
          end else begin
            state_nxt = srit_pkg::S_INS_RD;
          end
        end else if (count_r == '0) begin
          state_nxt = srit_pkg::S_EMIT;
        end else begin
          state_nxt = srit_pkg::S_LST_RD;
        end
      end
      srit_pkg::S_INS_RD:  state_nxt = srit_pkg::S_INS_CMP;
      srit_pkg::S_INS_CMP: begin
        if (!shift_down) begin
          state_nxt = srit_pkg::S_EMIT;
        end else if (ptr_r == srit_pkg::addr_t'(1)) begin
          state_nxt = srit_pkg::S_INS_PUT;
        end else begin
          state_nxt = srit_pkg::S_INS_RD;
        end
      end
      srit_pkg::S_INS_PUT: state_nxt = srit_pkg::S_EMIT;
      srit_pkg::S_LST_RD:  state_nxt = srit_pkg::S_LST_OUT;
      srit_pkg::S_LST_OUT: begin
        if (out_free) state_nxt = list_last ? srit_pkg::S_IDLE : srit_pkg::S_LST_RD;
      end
      srit_pkg::S_EMIT: begin
        if (out_free) state_nxt = srit_pkg::S_IDLE;
      end
      default: state_nxt = srit_pkg::S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    status_nxt     = status_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = new_entry;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;
    out_load       = 1'b0;
    out_status_nxt = status_r;
    out_entry_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      srit_pkg::S_IDLE: ;
      srit_pkg::S_DECODE: begin
        if (cmd_r == srit_pkg::CMD_INSERT) begin
          if (chk.full) begin
            status_nxt = srit_pkg::ST_FULL;
          end else if (chk.bad_day) begin
            status_nxt = srit_pkg::ST_BAD_DAY;
          end else if (chk.bad_time) begin
            status_nxt = srit_pkg::ST_BAD_TIME;
          end else if (count_r == '0) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            count_nxt  = count_r + srit_pkg::count_t'(1);
            status_nxt = srit_pkg::ST_INSERTED;
          end else begin
            // Not full, so the count fits the address width.
            ptr_nxt    = srit_pkg::addr_t'(count_r);
            status_nxt = srit_pkg::ST_INSERTED;
          end
        end else if (count_r == '0) begin
          status_nxt = srit_pkg::ST_EMPTY;
        end else begin
          ptr_nxt    = '0;
          status_nxt = srit_pkg::ST_ENTRY;
        end
      end
      srit_pkg::S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r - srit_pkg::addr_t'(1);
      end
      srit_pkg::S_INS_CMP: begin
        mem_we = 1'b1;
        if (shift_down) begin
          mem_wdata = rd_data_r;
          ptr_nxt   = ptr_r - srit_pkg::addr_t'(1);
        end else begin
          count_nxt = count_r + srit_pkg::count_t'(1);
        end
      end
      srit_pkg::S_INS_PUT: begin
        mem_we    = 1'b1;
        count_nxt = count_r + srit_pkg::count_t'(1);
      end
      srit_pkg::S_LST_RD: begin
        mem_re = 1'b1;
      end
      srit_pkg::S_LST_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = srit_pkg::ST_ENTRY;
          out_entry_nxt  = rd_data_r;
          out_last_nxt   = list_last;
          ptr_nxt        = ptr_r + srit_pkg::addr_t'(1);
        end
      end
      srit_pkg::S_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srit_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == srit_pkg::S_IDLE && in_valid) begin
      cmd_r    <= srit_pkg::cmd_t'(in_cmd);
      day_r    <= in_day_in;
      hour_r   <= in_hour_in;
      minute_r <= in_minute_in;
      tag_r    <= in_tag_in;
    end
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_entry_r  <= out_entry_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_day_out    = out_entry_r.day;
  assign out_hour_out   = out_entry_r.hour;
  assign out_minute_out = out_entry_r.minute;
  assign out_tag_out    = out_entry_r.tag;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

>>> rtl/srit_checker.sv
`default_nettype none

`include "sorted_reminder_insert_table_assert.svh"

module srit_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [4:0]  out_day_out,
  input wire logic [15:0] out_tag_out,
  input wire logic        out_last
);

  logic not_entry;

  assign not_entry = (out_status != 3'(srit_pkg::ST_ENTRY));

  // A stalled result holds its status.
  `SRIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))

  // One item at a time: the block is busy right after taking one.
  `SRIT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // Insert and empty results are single and final.
  `SRIT_ASSERT_NOW(a_single_last, out_valid && not_entry, out_last)

  // Only list entries carry entry fields.
  `SRIT_ASSERT_NOW(a_zero_fields, out_valid && not_entry,
                   out_day_out == 5'd0 && out_tag_out == 16'd0)

endmodule

bind sorted_reminder_insert_table srit_checker u_srit_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_status  (out_status),
  .out_day_out (out_day_out),
  .out_tag_out (out_tag_out),
  .out_last    (out_last)
);

`default_nettype wire
